/* design/jft_pkg.sv */
package jft_pkg;

    // Pipeline depth of the rotation unit and of the whole block
    localparam int CORDIC_STEPS = 24;
    localparam int ANG_LATENCY  = CORDIC_STEPS + 5;
    localparam int JFT_LATENCY  = ANG_LATENCY + 2;

    // Joint kind codes
    localparam logic [2:0] KIND_FIXED     = 3'd0;
    localparam logic [2:0] KIND_REVOLUTE  = 3'd1;
    localparam logic [2:0] KIND_PRISMATIC = 3'd2;
    localparam logic [2:0] KIND_FLOATING  = 3'd3;

    // Q.30 angle constants
    localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
    localparam logic signed [31:0] Q24_ONE     = 32'sd16777216;

    // floor(2^15 / 2pi): quotient estimate of (value * 32) / 2pi is (value * RECIP + 2^39) >> 40
    localparam logic [12:0] RECIP_TWO_PI = 13'd5215;
    localparam int          RECIP_SHIFT  = 40;

    localparam logic signed [33:0] ATAN_Q30 [0:30] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
        34'sd33543516,  34'sd16775851,  34'sd8388437,   34'sd4194283,   34'sd2097149,
        34'sd1048576,   34'sd524288,    34'sd262144,    34'sd131072,    34'sd65536,
        34'sd32768,     34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128,       34'sd64,
        34'sd32,        34'sd16,        34'sd8,         34'sd4,         34'sd2,
        34'sd1
    };

    typedef struct packed {
        logic [2:0]         joint_kind;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
        logic signed [31:0] value_e;
        logic signed [31:0] value_f;
        logic signed [31:0] value_g;
    } job_t;

    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic               kind_error;
    } result_t;

    // Half-angle cosine and sine in Q.30, leaving the rotation unit
    typedef struct packed {
        logic               valid;
        logic signed [32:0] cos_v;
        logic signed [32:0] sin_v;
    } ang_t;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -42'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // floor((p + 2^29) / 2^30), saturated
    function automatic logic signed [31:0] round_sat_q30(input logic signed [64:0] p);
        logic signed [65:0] t;
        logic signed [41:0] s;
        t = {p[64], p} + (66'sd1 <<< 29);
        s = {{6{t[65]}}, t[65:30]};
        return sat32(s);
    endfunction

    // floor((p + 2^23) / 2^24), saturated
    function automatic logic signed [31:0] round_sat_q24(input logic signed [64:0] p);
        logic signed [65:0] t;
        logic signed [41:0] s;
        t = {p[64], p} + (66'sd1 <<< 23);
        s = t[65:24];
        return sat32(s);
    endfunction

endpackage

/* design/jft_angle.sv */
module jft_angle (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [31:0]    angle,
    output jft_pkg::ang_t         ang
);
    import jft_pkg::*;

    // Reduction stages
    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [45:0]    p1_reg;
    logic signed [31:0]    a1_reg;
    logic signed [33:0]    r2_reg;
    logic signed [33:0]    r3_reg;

    // CORDIC stages: index 0 is the folded angle, index k is after k iterations
    logic                  cv_reg   [0:CORDIC_STEPS];
    logic                  flip_reg [0:CORDIC_STEPS];
    logic signed [32:0]    x_reg    [0:CORDIC_STEPS];
    logic signed [32:0]    y_reg    [0:CORDIC_STEPS];
    logic signed [33:0]    z_reg    [0:CORDIC_STEPS];

    logic                  vo_reg;
    logic signed [32:0]    c_reg, s_reg;

    logic signed [45:0]    rnd_next;
    logic signed [5:0]     quo_next;
    logic signed [40:0]    r2_next;
    logic signed [33:0]    r3_next;
    logic signed [33:0]    z0_next;
    logic                  flip0_next;

    always_comb
    begin
        rnd_next = p1_reg + (46'sd1 <<< (RECIP_SHIFT - 1));
        quo_next = rnd_next[45:40];
        r2_next  = {{4{a1_reg[31]}}, a1_reg, 5'b0} - (41'(quo_next) * 41'(TWO_PI_Q30));

        priority if (r2_reg >= PI_Q30)
        begin
            r3_next = r2_reg - TWO_PI_Q30;
        end
        else if (r2_reg < -PI_Q30)
        begin
            r3_next = r2_reg + TWO_PI_Q30;
        end
        else
        begin
            r3_next = r2_reg;
        end

        priority if (r3_reg > HALF_PI_Q30)
        begin
            z0_next    = r3_reg - PI_Q30;
            flip0_next = 1'b1;
        end
        else if (r3_reg < -HALF_PI_Q30)
        begin
            z0_next    = r3_reg + PI_Q30;
            flip0_next = 1'b1;
        end
        else
        begin
            z0_next    = r3_reg;
            flip0_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            cv_reg[0] <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            cv_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg      <= 46'(angle * $signed({1'b0, RECIP_TWO_PI}));
        a1_reg      <= angle;
        r2_reg      <= r2_next[33:0];
        r3_reg      <= r3_next;
        z_reg[0]    <= z0_next;
        flip_reg[0] <= flip0_next;
        x_reg[0]    <= GAIN_Q30;
        y_reg[0]    <= '0;
    end

    // One rotation per stage; rotate positive while the residual angle is not negative
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            flip_reg[i+1] <= flip_reg[i];
            if (!z_reg[i][33])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN_Q30[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN_Q30[i];
            end
        end
    end

    // Negate both for an angle folded by pi
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (flip_reg[CORDIC_STEPS])
        begin
            c_reg <= -x_reg[CORDIC_STEPS];
            s_reg <= -y_reg[CORDIC_STEPS];
        end
        else
        begin
            c_reg <= x_reg[CORDIC_STEPS];
            s_reg <= y_reg[CORDIC_STEPS];
        end
    end

    assign ang.valid = vo_reg;
    assign ang.cos_v = c_reg;
    assign ang.sin_v = s_reg;

endmodule

/* design/joint_frame_transform_top.sv */
// Joint frame transform: turns one joint description (kind, unit axis, up to seven
// Q8.24 variables) into the joint frame as a saturated Q8.24 translation and a
// quaternion (w,x,y,z). The block is a fixed-latency pipeline: it takes a new beat
// in every clock cycle (busy is never raised), and each result is shown on result
// for one cycle with done high, in the order the beats came in. The latency is set
// by the revolute path: three stages of modulo-2pi reduction (quotient estimate,
// subtract, wrap into one turn), one stage of quarter-turn folding, one stage per
// CORDIC iteration, a sign-fix stage, one multiply stage and one round-and-saturate
// stage. All kinds take the same path length. There is no back-pressure: the
// receiver must take every done beat.
// Unsupported kinds (4 to 7) return the identity frame with kind_error set.
module joint_frame_transform_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  jft_pkg::job_t    job,
    output logic             done,
    output jft_pkg::result_t result
);
    import jft_pkg::*;

    // Never stall: every start beat enters the pipeline
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    ang_t ang;

    jft_angle u_angle (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .angle    (job.value_a),
        .ang      (ang)
    );

    // Carry the beat alongside the rotation unit; validity travels inside it
    job_t side_reg [0:ANG_LATENCY-1];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= job;
        for (int k = 1; k < ANG_LATENCY; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Multiply stage: axis times sine for revolute, axis times distance otherwise
    job_t               job_a;
    logic signed [32:0] mul_b;
    assign job_a = side_reg[ANG_LATENCY-1];
    assign mul_b = (job_a.joint_kind == KIND_REVOLUTE) ? ang.sin_v
                                                       : {job_a.value_a[31], job_a.value_a};

    logic               vm_reg;
    job_t               jm_reg;
    logic signed [32:0] cm_reg;
    logic signed [64:0] px_reg, py_reg, pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else
        begin
            vm_reg <= ang.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        jm_reg <= job_a;
        cm_reg <= ang.cos_v;
        px_reg <= 65'(job_a.axis_x) * 65'(mul_b);
        py_reg <= 65'(job_a.axis_y) * 65'(mul_b);
        pz_reg <= 65'(job_a.axis_z) * 65'(mul_b);
    end

    // Select by kind, round and saturate
    result_t            res_next;
    logic signed [33:0] cos_rnd;

    always_comb
    begin
        cos_rnd  = {cm_reg[32], cm_reg} + 34'sd32;
        res_next = '0;
        res_next.quat_w = Q24_ONE;
        unique case (jm_reg.joint_kind)
            KIND_FIXED:
            begin
                res_next.kind_error = 1'b0;
            end
            KIND_REVOLUTE:
            begin
                res_next.quat_w = {{4{cos_rnd[33]}}, cos_rnd[33:6]};
                res_next.quat_x = round_sat_q30(px_reg);
                res_next.quat_y = round_sat_q30(py_reg);
                res_next.quat_z = round_sat_q30(pz_reg);
            end
            KIND_PRISMATIC:
            begin
                res_next.trans_x = round_sat_q24(px_reg);
                res_next.trans_y = round_sat_q24(py_reg);
                res_next.trans_z = round_sat_q24(pz_reg);
            end
            KIND_FLOATING:
            begin
                res_next.trans_x = jm_reg.value_a;
                res_next.trans_y = jm_reg.value_b;
                res_next.trans_z = jm_reg.value_c;
                res_next.quat_x  = jm_reg.value_d;
                res_next.quat_y  = jm_reg.value_e;
                res_next.quat_z  = jm_reg.value_f;
                res_next.quat_w  = jm_reg.value_g;
            end
            default:
            begin
                // planar and unknown kinds: identity with the error flag
                res_next.kind_error = 1'b1;
            end
        endcase
    end

    logic    done_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* design/jft_checker.sv */
module jft_assertions (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input jft_pkg::job_t    job,
    input logic             done,
    input jft_pkg::result_t result
);
    import jft_pkg::*;

    // Each accepted beat yields a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##JFT_LATENCY done)
        else $error("accepted beat produced no result on time");

    // No result without a matching accepted beat
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, JFT_LATENCY))
        else $error("result without an accepted beat");

    // A fixed joint gives no error, a unit quat_w and zero trans_x and quat_x
    a_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && job.joint_kind == KIND_FIXED) |-> ##JFT_LATENCY
        (done && !result.kind_error && result.quat_w == Q24_ONE
         && result.trans_x == 32'sd0 && result.quat_x == 32'sd0))
        else $error("fixed joint did not give the identity");

    // An error result is always the identity frame
    a_err_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.kind_error) |->
        (result.quat_w == Q24_ONE && result.quat_x == 32'sd0 && result.quat_y == 32'sd0
         && result.quat_z == 32'sd0 && result.trans_x == 32'sd0
         && result.trans_y == 32'sd0 && result.trans_z == 32'sd0))
        else $error("error result is not the identity");

endmodule

bind joint_frame_transform_top jft_assertions u_jft_assertions (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .job    (job),
    .done   (done),
    .result (result)
);

/* sim/jft_checker.sv */
module jft_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  jft_pkg::job_t    job,
    input  logic             done,
    input  jft_pkg::result_t result,
    output int               mismatches,
    output int               waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import jft_pkg::*;

    localparam longint TWO_PI_R  = 64'sd6746518852;
    localparam longint PI_R      = 64'sd3373259426;
    localparam longint HALF_PI_R = 64'sd1686629713;
    localparam longint GAIN_R    = 64'sd652032874;
    localparam longint ONE_Q24   = 64'sd16777216;

    localparam longint ARCTAN_R [0:30] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
        64'sd33543516,  64'sd16775851,  64'sd8388437,   64'sd4194283,   64'sd2097149,
        64'sd1048576,   64'sd524288,    64'sd262144,    64'sd131072,    64'sd65536,
        64'sd32768,     64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128,       64'sd64,
        64'sd32,        64'sd16,        64'sd8,         64'sd4,         64'sd2,
        64'sd1
    };

    result_t frame_q [$];
    int      fail_tally = 0;

    assign mismatches = fail_tally;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Half angle in Q.30 is the Q8.24 angle times 32; fold into [-pi/2, pi/2] first
    function automatic void half_angle_cordic(input logic signed [31:0] ang,
                                              output longint c, output longint s);
        longint r;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        r    = (longint'(ang) * 64'sd32) % TWO_PI_R;
        flip = 1'b0;
        x    = GAIN_R;
        y    = 0;
        if (r < 0)
        begin
            r = r + TWO_PI_R;
        end
        if (r >= PI_R)
        begin
            r = r - TWO_PI_R;
        end
        if (r > HALF_PI_R)
        begin
            r    = r - PI_R;
            flip = 1'b1;
        end
        else if (r < -HALF_PI_R)
        begin
            r    = r + PI_R;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 31; i++)
        begin
            if (r >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                r  = r - ARCTAN_R[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                r  = r + ARCTAN_R[i];
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic result_t joint_frame(input job_t j);
        result_t f;
        longint  c;
        longint  s;
        longint  span;
        f        = '0;
        f.quat_w = ONE_Q24[31:0];
        span     = longint'($signed(j.value_a));
        case (j.joint_kind)
            KIND_FIXED:
            begin
            end
            KIND_REVOLUTE:
            begin
                half_angle_cordic(j.value_a, c, s);
                f.quat_w = clamp32((c + 64'sd32) >>> 6);
                f.quat_x = clamp32((longint'($signed(j.axis_x)) * s + (64'sd1 <<< 29)) >>> 30);
                f.quat_y = clamp32((longint'($signed(j.axis_y)) * s + (64'sd1 <<< 29)) >>> 30);
                f.quat_z = clamp32((longint'($signed(j.axis_z)) * s + (64'sd1 <<< 29)) >>> 30);
            end
            KIND_PRISMATIC:
            begin
                f.trans_x = clamp32((longint'($signed(j.axis_x)) * span + (64'sd1 <<< 23)) >>> 24);
                f.trans_y = clamp32((longint'($signed(j.axis_y)) * span + (64'sd1 <<< 23)) >>> 24);
                f.trans_z = clamp32((longint'($signed(j.axis_z)) * span + (64'sd1 <<< 23)) >>> 24);
            end
            KIND_FLOATING:
            begin
                f.trans_x = j.value_a;
                f.trans_y = j.value_b;
                f.trans_z = j.value_c;
                f.quat_x  = j.value_d;
                f.quat_y  = j.value_e;
                f.quat_z  = j.value_f;
                f.quat_w  = j.value_g;
            end
            default:
            begin
                f.kind_error = 1'b1;
            end
        endcase
        return f;
    endfunction

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
            fail_tally++;
        end
    endtask

    // Retire the oldest frame on done, then queue the frame for a newly taken beat
    always @(posedge clk)
    begin : watch
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (frame_q.size() == 0)
                begin
                    $display("%0t: result beat with no frame pending, got %h", $time, result);
                    fail_tally++;
                end
                else
                begin
                    want = frame_q.pop_front();
                    compare_field("trans_x", want.trans_x, result.trans_x);
                    compare_field("trans_y", want.trans_y, result.trans_y);
                    compare_field("trans_z", want.trans_z, result.trans_z);
                    compare_field("quat_w", want.quat_w, result.quat_w);
                    compare_field("quat_x", want.quat_x, result.quat_x);
                    compare_field("quat_y", want.quat_y, result.quat_y);
                    compare_field("quat_z", want.quat_z, result.quat_z);
                    compare_field("kind_error", 32'(want.kind_error), 32'(result.kind_error));
                end
            end
            if (start && !busy)
            begin
                frame_q.push_back(joint_frame(job));
            end
        end
        waiting <= frame_q.size();
    end

endmodule

/* sim/tb_joint_frame_transform_top.sv */
module tb_joint_frame_transform_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jft_pkg::*;

    // Codes 4 to 7 are all unsupported kinds (planar among them)
    localparam logic [2:0] KIND_OTHER_FIRST = 3'd4;

    localparam int RANDOM_JOBS  = 450;
    localparam int QUIET_TAIL   = 60;
    localparam int STALL_LIMIT  = 600;

    localparam logic signed [31:0] ONE     = 32'sd16777216;
    localparam logic signed [31:0] MAX_S32 = 32'sh7fffffff;
    localparam logic signed [31:0] MIN_S32 = 32'sh80000000;
    // Angles whose half lands right at the quarter-turn fold and at the half-turn wrap
    localparam logic signed [31:0] FOLD_ANG = 32'sd52707179;
    localparam logic signed [31:0] WRAP_ANG = 32'sd105414357;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    job_t    job = '0;
    logic    done;
    result_t result;

    int mismatches;
    int waiting;
    int quiet_cycles = 0;

    job_t directed_q [$];

    always #6 clk = ~clk;

    joint_frame_transform_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .job    (job),
        .done   (done),
        .result (result)
    );

    jft_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .job        (job),
        .done       (done),
        .result     (result),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    // Watchdog: count cycles where no beat moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("joint_frame_transform_top test failed");
                $finish;
            end
        end
    end

    // Build one job; the values the kind does not use get random bits
    function automatic job_t make_job(input logic [2:0] kind, input logic signed [31:0] ax,
                                      input logic signed [31:0] ay,
                                      input logic signed [31:0] az,
                                      input logic signed [31:0] va);
        job_t j;
        j.joint_kind = kind;
        j.axis_x     = ax;
        j.axis_y     = ay;
        j.axis_z     = az;
        j.value_a    = va;
        j.value_b    = $urandom;
        j.value_c    = $urandom;
        j.value_d    = $urandom;
        j.value_e    = $urandom;
        j.value_f    = $urandom;
        j.value_g    = $urandom;
        return j;
    endfunction

    // Mostly unit-scale components, some full-width garbage
    function automatic logic signed [31:0] rand_axis_comp();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1, 2:    v = $signed($urandom_range(0, 2 * 16777216)) - ONE;
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       v = 32'sd0;
                    1:       v = ONE;
                    default: v = -ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    // Spread angles over the full range, a few turns, the fold edges and near zero
    function automatic logic signed [31:0] rand_angle();
        logic signed [31:0] v;
        logic signed [31:0] nudge;
        nudge = $signed($urandom_range(0, 64)) - 32;
        case ($urandom_range(0, 4))
            0:       v = $urandom;
            1, 2:    v = $signed($urandom_range(0, 1 << 29)) - (32'sd1 <<< 28);
            3:
            begin
                v = ($urandom_range(0, 1) != 0) ? FOLD_ANG + nudge : WRAP_ANG + nudge;
                if ($urandom_range(0, 1) != 0)
                begin
                    v = -v;
                end
            end
            default: v = nudge;
        endcase
        return v;
    endfunction

    function automatic job_t rand_job();
        job_t        j;
        int unsigned pick;
        logic [2:0]  kind;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            kind = KIND_REVOLUTE;
        end
        else if (pick < 65)
        begin
            kind = KIND_PRISMATIC;
        end
        else if (pick < 85)
        begin
            kind = KIND_FLOATING;
        end
        else if (pick < 93)
        begin
            kind = KIND_FIXED;
        end
        else
        begin
            kind = KIND_OTHER_FIRST + 3'($urandom_range(0, 3));
        end
        j = make_job(kind, rand_axis_comp(), rand_axis_comp(), rand_axis_comp(), rand_angle());
        // Prismatic distances: half from the angle spread, half full width
        if (kind == KIND_PRISMATIC && $urandom_range(0, 1) != 0)
        begin
            j.value_a = $urandom;
        end
        return j;
    endfunction

    // Present one beat and hold it until the block takes it
    task automatic send_beat(input job_t j);
        start <= 1'b1;
        job   <= j;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        job_t j;
        int   total;
        bit   gaps_on;
        gaps_on = 1'b1;

        // Directed beats: every kind, field extremes, fold and wrap edges, saturation
        directed_q.push_back(make_job(KIND_FIXED, $urandom, $urandom, $urandom, $urandom));
        directed_q.push_back(make_job(KIND_REVOLUTE, 32'sd0, 32'sd0, ONE, 32'sd0));
        directed_q.push_back(make_job(KIND_REVOLUTE, 32'sd0, 32'sd0, ONE, FOLD_ANG));
        directed_q.push_back(make_job(KIND_REVOLUTE, 32'sd0, 32'sd0, ONE, FOLD_ANG - 1));
        directed_q.push_back(make_job(KIND_REVOLUTE, ONE, 32'sd0, 32'sd0, -FOLD_ANG));
        directed_q.push_back(make_job(KIND_REVOLUTE, ONE, 32'sd0, 32'sd0, 1 - FOLD_ANG));
        directed_q.push_back(make_job(KIND_REVOLUTE, 32'sd0, ONE, 32'sd0, WRAP_ANG));
        directed_q.push_back(make_job(KIND_REVOLUTE, 32'sd0, ONE, 32'sd0, WRAP_ANG + 1));
        directed_q.push_back(make_job(KIND_REVOLUTE, 32'sd0, -ONE, 32'sd0, -WRAP_ANG - 1));
        directed_q.push_back(make_job(KIND_REVOLUTE, ONE, 32'sd0, 32'sd0, MAX_S32));
        directed_q.push_back(make_job(KIND_REVOLUTE, 32'sd0, ONE, 32'sd0, MIN_S32));
        directed_q.push_back(make_job(KIND_REVOLUTE, -ONE, ONE, -ONE, -32'sd1));
        // Sine near +/-1 against extreme axis components drives the products to the rails
        directed_q.push_back(make_job(KIND_REVOLUTE, MIN_S32, MAX_S32, MIN_S32, FOLD_ANG));
        directed_q.push_back(make_job(KIND_REVOLUTE, MIN_S32, MAX_S32, MIN_S32, -FOLD_ANG));
        directed_q.push_back(make_job(KIND_PRISMATIC, ONE, 32'sd0, 32'sd0, ONE));
        directed_q.push_back(make_job(KIND_PRISMATIC, MAX_S32, MIN_S32, MIN_S32, MIN_S32));
        directed_q.push_back(make_job(KIND_PRISMATIC, MAX_S32, MIN_S32, -32'sd1, MAX_S32));
        directed_q.push_back(make_job(KIND_PRISMATIC, -ONE, ONE, ONE, 32'sd0));
        j = make_job(KIND_FLOATING, $urandom, $urandom, $urandom, MAX_S32);
        {j.value_b, j.value_c, j.value_d, j.value_e, j.value_f, j.value_g} = {6{MAX_S32}};
        directed_q.push_back(j);
        j = make_job(KIND_FLOATING, $urandom, $urandom, $urandom, MIN_S32);
        {j.value_b, j.value_c, j.value_d, j.value_e, j.value_f, j.value_g} = {6{MIN_S32}};
        directed_q.push_back(j);
        directed_q.push_back(make_job(KIND_FLOATING, $urandom, $urandom, $urandom, $urandom));
        for (int k = 0; k < 4; k++)
        begin
            directed_q.push_back(make_job(KIND_OTHER_FIRST + 3'(k), $urandom, $urandom,
                                          $urandom, $urandom));
        end

        // Hold reset, then release it at an edge
        repeat (4)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        total = directed_q.size() + RANDOM_JOBS;
        for (int n = 0; n < total; n++)
        begin
            // Switch gaps on and off in stretches so some runs go back to back
            if (n % 40 == 0)
            begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if (n < directed_q.size())
            begin
                j = directed_q[n];
            end
            else
            begin
                j = rand_job();
            end
            send_beat(j);
            // Drop start for a burst now and then; keep the tail gap-free
            if (n < total - QUIET_TAIL && gaps_on && $urandom_range(0, 99) < 35)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 13))
                begin
                    @(posedge clk);
                end
            end
        end
        start <= 1'b0;

        // Drain: wait for every frame, then give the pipeline time to show strays
        @(posedge clk);
        while (waiting != 0)
        begin
            @(posedge clk);
        end
        repeat (JFT_LATENCY + 4)
        begin
            @(posedge clk);
        end

        if (mismatches == 0 && waiting == 0)
        begin
            $display("joint_frame_transform_top test passed");
        end
        else
        begin
            $display("joint_frame_transform_top test failed");
        end
        $finish;
    end

endmodule
